@@ sv/hwc_pkg.sv @@
// Hann window coefficient generator: shared package.
// Holds field widths, fixed-point constants, the control struct and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hwc_pkg;

	// Field widths
	localparam int LEN_W   = 13;
	localparam int INDEX_W = 12;
	localparam int COEF_W  = 16;

	// Datapath widths
	localparam int PHASE_W = 32;   // phase quotient, Q0.32 of a half turn
	localparam int ANGLE_W = 31;   // angle in Q2.30, at most pi/2
	localparam int SQ_W    = 32;   // squared angle in Q2.30
	localparam int TERM_W  = 31;   // Horner term, within [0, 1.0] in Q2.30

	// Fixed-point constants
	localparam logic [PHASE_W-1:0] PI_Q30    = 32'd3373259426;
	localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic [TERM_W-1:0]  Q30_ONE   = 31'h4000_0000;
	localparam logic [COEF_W-1:0]  COEF_ONE  = 16'h8000;

	// Phase divider: quotient bits per pipeline stage
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES         = PHASE_W / DIV_BITS_PER_STAGE;

	// Taylor sine in Horner form, innermost divisor first
	localparam int SERIES_TERMS = 5;
	localparam int SERIES_DIV [SERIES_TERMS] = '{110, 72, 42, 20, 6};

	// Register reset values
	localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = 13'd512;

	// Configuration register indexes
	typedef enum logic {
		REG_WINDOW_LENGTH = 1'b0,
		REG_PERIODIC_MODE = 1'b1
	} cfg_reg_t;

	// Control that travels with each request down the pipeline
	typedef struct packed {
		logic valid;
		logic oor;
	} hwc_ctrl_t;

endpackage

`default_nettype wire

@@ sv/hann_window_coefficient.sv @@
// Hann window coefficient generator: top level.
// Uses hwc_pkg, hwc_div_stage and hwc_series_term.
//
// Usage: write window_length (index 0) and periodic_mode (index 1) through
// cfg_we / cfg_index / cfg_wdata while no request is in flight. A request is
// taken at a rising edge with start high and busy low; sample_index is the
// position i. Symmetric mode returns 0.5*(1-cos(2*pi*(i+1)/(N+1))), periodic
// mode 0.5*(1-cos(2*pi*i/N)), as unsigned Q1.15 where 32768 is 1.0. An index
// at or beyond N returns zero with index_out_of_range set.
// Throughput: one request per clock while busy is low. The pipeline is 37
// stages deep: done is registered in the last stage and stays high for one
// cycle, with coefficient and index_out_of_range valid in that cycle. The
// depth comes mainly from the 8-stage phase divider (4 quotient bits per
// stage) and the five 4-stage Horner steps of the sine series.
// Reset: window_length returns to 512, periodic_mode to 0, the pipeline
// empties, and busy stays high for the first cycle after reset release.
// The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none

module hann_window_coefficient
	import hwc_pkg::*;
#(
	parameter int MAX_WINDOW_LENGTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [LEN_W-1:0]   cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [INDEX_W-1:0] sample_index,
	output logic               done,
	output logic [COEF_W-1:0]  coefficient,
	output logic               index_out_of_range
);

	// Saturation length and divisor width follow from the maximum window length
	localparam int SAT_INT = (MAX_WINDOW_LENGTH > (2**LEN_W - 1)) ?
		(2**LEN_W - 1) : MAX_WINDOW_LENGTH;
	localparam int DW = $clog2(SAT_INT + 2);
	localparam logic [LEN_W-1:0] SAT_LEN = LEN_W'(SAT_INT);
	localparam int LAT = 37;

	logic [LEN_W-1:0] window_length_q;
	logic             periodic_mode_q;
	logic             busy_q;

	logic [LEN_W-1:0] len_sat;
	logic             oor_in;
	logic [DW-1:0]    num_in;
	logic [DW-1:0]    dvs_in;

	hwc_ctrl_t        ctrl_s1;
	logic [DW-1:0]    rem_s1;
	logic [DW-1:0]    dvs_s1;

	hwc_ctrl_t          div_ctrl [DIV_STAGES+1];
	logic [DW-1:0]      div_rem  [DIV_STAGES+1];
	logic [DW-1:0]      div_dvs  [DIV_STAGES+1];
	logic [PHASE_W-1:0] div_quo  [DIV_STAGES+1];

	hwc_ctrl_t              ctrl_s10, ctrl_s11, ctrl_s12, ctrl_s13, ctrl_s14;
	logic [PHASE_W-1:0]     fold_s10;
	logic [2*PHASE_W-1:0]   angle_prod_s11;
	logic [ANGLE_W-1:0]     angle_s12, angle_s13, angle_s14;
	logic [2*ANGLE_W-1:0]   angle_sq_prod_s13;
	logic [SQ_W-1:0]        angle_sq_s14;

	hwc_ctrl_t          ser_ctrl     [SERIES_TERMS+1];
	logic [ANGLE_W-1:0] ser_angle    [SERIES_TERMS+1];
	logic [SQ_W-1:0]    ser_angle_sq [SERIES_TERMS+1];
	logic [TERM_W-1:0]  ser_term     [SERIES_TERMS+1];

	hwc_ctrl_t              ctrl_s35, ctrl_s36;
	logic [ANGLE_W+TERM_W-1:0] sine_prod_s35;
	logic [ANGLE_W-1:0]     sine;
	logic [2*ANGLE_W-1:0]   sine_sq_s36;
	logic [2*ANGLE_W:0]     sine_sq_rnd;
	logic [COEF_W+1:0]      coef_wide;
	logic [COEF_W-1:0]      coef_next;

	logic                done_s37;
	logic                oor_s37;
	logic [COEF_W-1:0]   coef_s37;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RESET;
			periodic_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LENGTH: window_length_q <= cfg_wdata;
				REG_PERIODIC_MODE: periodic_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Hold busy for one cycle after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	// Saturate the length, check the index, pick numerator and divisor
	always_comb begin
		len_sat = (window_length_q > SAT_LEN) ? SAT_LEN : window_length_q;
		oor_in  = LEN_W'(sample_index) >= len_sat;
		if (periodic_mode_q) begin
			num_in = DW'(sample_index);
			dvs_in = DW'(len_sat);
		end else begin
			num_in = DW'(LEN_W'(sample_index) + LEN_W'(1));
			dvs_in = DW'({1'b0, len_sat} + (LEN_W + 1)'(1));
		end
	end

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= start && !busy_q;
			ctrl_s1.oor   <= oor_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= num_in;
		dvs_s1 <= dvs_in;
	end

	// Phase divider: F = (k * 2^32 + D/2) / D
	assign div_ctrl[0] = ctrl_s1;
	assign div_rem[0]  = rem_s1;
	assign div_dvs[0]  = dvs_s1;
	assign div_quo[0]  = '0;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		hwc_div_stage #(
			.DW      (DW),
			.TOP_BIT (PHASE_W - 1 - g * DIV_BITS_PER_STAGE)
		) u_div_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (div_ctrl[g]),
			.rem     (div_rem[g]),
			.dvs     (div_dvs[g]),
			.quo     (div_quo[g]),
			.ctrl_s1 (div_ctrl[g+1]),
			.rem_s1  (div_rem[g+1]),
			.dvs_s1  (div_dvs[g+1]),
			.quo_s1  (div_quo[g+1])
		);
	end

	// Advance control through the angle and square stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s10 <= '0;
			ctrl_s11 <= '0;
			ctrl_s12 <= '0;
			ctrl_s13 <= '0;
			ctrl_s14 <= '0;
		end else begin
			ctrl_s10 <= div_ctrl[DIV_STAGES];
			ctrl_s11 <= ctrl_s10;
			ctrl_s12 <= ctrl_s11;
			ctrl_s13 <= ctrl_s12;
			ctrl_s14 <= ctrl_s13;
		end
	end

	// Fold the phase onto the first quarter, scale by pi, square the angle
	always_ff @(posedge clk) begin
		fold_s10 <= (div_quo[DIV_STAGES] > HALF_TURN) ?
			(~div_quo[DIV_STAGES] + PHASE_W'(1)) : div_quo[DIV_STAGES];

		angle_prod_s11 <= fold_s10 * PI_Q30;

		angle_s12 <= ANGLE_W'((angle_prod_s11 + (2*PHASE_W)'(HALF_TURN)) >> PHASE_W);

		angle_sq_prod_s13 <= angle_s12 * angle_s12;
		angle_s13         <= angle_s12;

		angle_sq_s14 <= SQ_W'((angle_sq_prod_s13 + (2*ANGLE_W)'(1 << 29)) >> 30);
		angle_s14    <= angle_s13;
	end

	// Horner evaluation of sin(y)/y
	assign ser_ctrl[0]     = ctrl_s14;
	assign ser_angle[0]    = angle_s14;
	assign ser_angle_sq[0] = angle_sq_s14;
	assign ser_term[0]     = Q30_ONE;

	for (genvar h = 0; h < SERIES_TERMS; h++) begin : g_series
		hwc_series_term #(
			.DIVISOR (SERIES_DIV[h])
		) u_series_term (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ser_ctrl[h]),
			.angle       (ser_angle[h]),
			.angle_sq    (ser_angle_sq[h]),
			.term        (ser_term[h]),
			.ctrl_s4     (ser_ctrl[h+1]),
			.angle_s4    (ser_angle[h+1]),
			.angle_sq_s4 (ser_angle_sq[h+1]),
			.term_s4     (ser_term[h+1])
		);
	end

	// Sine, its square, then round and clamp to Q1.15, or zero when out of range
	assign sine        = sine_prod_s35[30 +: ANGLE_W];
	assign sine_sq_rnd = {1'b0, sine_sq_s36} + (2*ANGLE_W + 1)'(64'd1 << 44);
	assign coef_wide   = sine_sq_rnd[45 +: COEF_W + 2];

	always_comb begin
		if (ctrl_s36.oor) begin
			coef_next = '0;
		end else if (coef_wide > (COEF_W + 2)'(COEF_ONE)) begin
			coef_next = COEF_ONE;
		end else begin
			coef_next = coef_wide[COEF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s35 <= '0;
			ctrl_s36 <= '0;
			done_s37 <= 1'b0;
		end else begin
			ctrl_s35 <= ser_ctrl[SERIES_TERMS];
			ctrl_s36 <= ctrl_s35;
			done_s37 <= ctrl_s36.valid;
		end
	end

	always_ff @(posedge clk) begin
		sine_prod_s35 <= ser_angle[SERIES_TERMS] * ser_term[SERIES_TERMS];
		sine_sq_s36   <= sine * sine;
		coef_s37      <= coef_next;
		oor_s37       <= ctrl_s36.oor;
	end

	// Drive the result ports
	assign done               = done_s37;
	assign coefficient        = coef_s37;
	assign index_out_of_range = oor_s37;

	// Every accepted request gives a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted request produced no result");

	// No result without a matching earlier request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	// Out-of-range results carry a zero coefficient
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_out_of_range) |-> (coefficient == '0))
		else $error("out-of-range result has nonzero coefficient");

	// Folded phase never exceeds a quarter turn of the sine
	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s10.valid |-> (fold_s10 <= HALF_TURN))
		else $error("phase fold out of range");

	// Horner term stays within [0, 1.0]
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		ser_ctrl[SERIES_TERMS].valid |-> (ser_term[SERIES_TERMS] <= Q30_ONE))
		else $error("series term above 1.0");

endmodule

`default_nettype wire

@@ sv/hwc_div_stage.sv @@
// Hann window coefficient generator: one stage of the phase divider.
// Restoring division, DIV_BITS_PER_STAGE quotient bits per stage, registered output.
// Depends on hwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hwc_div_stage
	import hwc_pkg::*;
#(
	parameter int DW      = 13,
	parameter int TOP_BIT = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hwc_ctrl_t          ctrl,
	input  logic [DW-1:0]      rem,
	input  logic [DW-1:0]      dvs,
	input  logic [PHASE_W-1:0] quo,
	output hwc_ctrl_t          ctrl_s1,
	output logic [DW-1:0]      rem_s1,
	output logic [DW-1:0]      dvs_s1,
	output logic [PHASE_W-1:0] quo_s1
);

	logic [PHASE_W-1:0] half_ext;
	logic [DW:0]        trial;
	logic [DW-1:0]      rem_nxt;
	logic [PHASE_W-1:0] quo_nxt;

	// Shift in the rounding bias D/2 one bit per step, subtract where it fits
	always_comb begin
		half_ext = PHASE_W'(dvs >> 1);
		rem_nxt  = rem;
		quo_nxt  = quo;
		trial    = '0;
		for (int s = 0; s < DIV_BITS_PER_STAGE; s++) begin
			trial = {rem_nxt, half_ext[TOP_BIT - s]};
			if (trial >= {1'b0, dvs}) begin
				trial   = trial - {1'b0, dvs};
				quo_nxt = {quo_nxt[PHASE_W-2:0], 1'b1};
			end else begin
				quo_nxt = {quo_nxt[PHASE_W-2:0], 1'b0};
			end
			rem_nxt = trial[DW-1:0];
		end
	end

	// Advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		rem_s1 <= rem_nxt;
		dvs_s1 <= dvs;
		quo_s1 <= quo_nxt;
	end

endmodule

`default_nettype wire

@@ sv/hwc_series_term.sv @@
// Hann window coefficient generator: one Horner step of the Taylor sine.
// Computes t' = 1.0 - ((y2*t) >> 30) / DIVISOR over four register stages.
// Depends on hwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hwc_series_term
	import hwc_pkg::*;
#(
	parameter int DIVISOR = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hwc_ctrl_t         ctrl,
	input  logic [ANGLE_W-1:0] angle,
	input  logic [SQ_W-1:0]   angle_sq,
	input  logic [TERM_W-1:0] term,
	output hwc_ctrl_t         ctrl_s4,
	output logic [ANGLE_W-1:0] angle_s4,
	output logic [SQ_W-1:0]   angle_sq_s4,
	output logic [TERM_W-1:0] term_s4
);

	// Reciprocal floor(2^32 / DIVISOR); the estimate is short by at most one
	localparam logic [SQ_W-1:0] RECIP = SQ_W'((64'd1 << 32) / DIVISOR);
	// Residual stays below twice the divisor
	localparam int              RW     = $clog2(2 * DIVISOR + 1);
	localparam logic [RW-1:0]   DIV_RW = RW'(DIVISOR);

	hwc_ctrl_t          ctrl_s1, ctrl_s2, ctrl_s3;
	logic [ANGLE_W-1:0] angle_s1, angle_s2, angle_s3;
	logic [SQ_W-1:0]    angle_sq_s1, angle_sq_s2, angle_sq_s3;
	logic [SQ_W-1:0]    x_s1, x_s2;
	logic [SQ_W-1:0]    q0_s2, q0_s3;
	logic [RW-1:0]      res_s3;

	logic [SQ_W+TERM_W-1:0] prod_sq;
	logic [2*SQ_W-1:0]      prod_recip;
	logic [SQ_W-1:0]        dec;

	assign prod_sq    = angle_sq * term;
	assign prod_recip = x_s1 * RECIP;
	assign dec        = q0_s3 + SQ_W'(res_s3 >= DIV_RW);

	// Advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
		end
	end

	// Multiply, estimate quotient, form residual, correct and update the term
	always_ff @(posedge clk) begin
		x_s1        <= prod_sq[30 +: SQ_W];
		angle_s1    <= angle;
		angle_sq_s1 <= angle_sq;

		x_s2        <= x_s1;
		q0_s2       <= prod_recip[SQ_W +: SQ_W];
		angle_s2    <= angle_s1;
		angle_sq_s2 <= angle_sq_s1;

		res_s3      <= x_s2[RW-1:0] - RW'(q0_s2 * DIV_RW);
		q0_s3       <= q0_s2;
		angle_s3    <= angle_s2;
		angle_sq_s3 <= angle_sq_s2;

		term_s4     <= (dec > SQ_W'(Q30_ONE)) ? '0 : TERM_W'(SQ_W'(Q30_ONE) - dec);
		angle_s4    <= angle_s3;
		angle_sq_s4 <= angle_sq_s3;
	end

endmodule

`default_nettype wire

@@ bench/hann_window_coefficient_tb.sv @@
// Testbench for the Hann window coefficient generator.
// Drives sample index requests and register writes, predicts each coefficient in
// bit-exact fixed point and checks every strobed result. Depends on hwc_pkg and the RTL.
`timescale 1ns / 1ps

module hann_window_coefficient_tb;
	import hwc_pkg::*;

	localparam int MAX_LEN      = 4096;
	localparam int PIPE_DEPTH   = 37;
	localparam int STALL_LIMIT  = 4000;
	localparam int RAND_PHASES  = 14;
	localparam int PHASE_ITEMS  = 100;

	typedef struct {
		logic [COEF_W-1:0] coef;
		logic              oor;
	} hann_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = REG_WINDOW_LENGTH;
	logic [LEN_W-1:0]   cfg_wdata = '0;
	logic               start = 1'b0;
	logic               busy;
	logic [INDEX_W-1:0] sample_index = '0;
	logic               done;
	logic [COEF_W-1:0]  coefficient;
	logic               index_out_of_range;

	// Mirror of the block's registers, updated on the same edge as the block
	logic [LEN_W-1:0]   model_len = WINDOW_LENGTH_RESET;
	logic               model_periodic = 1'b0;

	logic [INDEX_W-1:0] pending_index[$];
	hann_result_t       coef_expected[$];
	logic               took = 1'b0;
	int                 gap_pct = 0;
	int                 errors = 0;
	int                 idle_cycles = 0;

	hann_window_coefficient dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.start             (start),
		.busy              (busy),
		.sample_index      (sample_index),
		.done              (done),
		.coefficient       (coefficient),
		.index_out_of_range(index_out_of_range)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// sin(pi*k/d)^2 in Q1.15 through the block's fixed-point steps
	function automatic logic [COEF_W-1:0] sine_squared_q15(input logic [63:0] k,
			input logic [63:0] d);
		logic [63:0] f, y, y2, t, s, c, dec;
		f = ((k << 32) + (d >> 1)) / d;
		if (f > 64'h8000_0000)
			f = 64'h1_0000_0000 - f;
		y  = (f * 64'(PI_Q30) + 64'h8000_0000) >> 32;
		y2 = (y * y + 64'h2000_0000) >> 30;
		t  = 64'(Q30_ONE);
		for (int n = 0; n < SERIES_TERMS; n++) begin
			dec = ((y2 * t) >> 30) / 64'(SERIES_DIV[n]);
			t = (dec > 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - dec;
		end
		s = (y * t) >> 30;
		c = (s * s + 64'h1000_0000_0000) >> 45;
		if (c > 64'd32768)
			c = 64'd32768;
		return c[COEF_W-1:0];
	endfunction

	// Expected result for one index under the given register values
	function automatic hann_result_t hann_predict(input logic [INDEX_W-1:0] idx,
			input logic [LEN_W-1:0] len, input logic periodic);
		hann_result_t r;
		logic [63:0]  n_eff;
		n_eff = (len > MAX_LEN) ? 64'(MAX_LEN) : 64'(len);
		if (64'(idx) >= n_eff) begin
			r.coef = '0;
			r.oor  = 1'b1;
		end else begin
			r.oor  = 1'b0;
			if (periodic)
				r.coef = sine_squared_q15(64'(idx), n_eff);
			else
				r.coef = sine_squared_q15(64'(idx) + 64'd1, n_eff + 64'd1);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Driver: hold a request until taken, then maybe idle, then issue the next one
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_index.size() > 0 && $urandom_range(99) >= gap_pct) begin
				start        <= 1'b1;
				sample_index <= pending_index.pop_front();
			end else begin
				start        <= 1'b0;
				sample_index <= INDEX_W'($urandom());
			end
		end
	end

	// Monitor: record requests, check results, mirror register writes, watch for stalls
	always @(posedge clk or negedge arst_n) begin
		hann_result_t want;
		if (!arst_n) begin
			model_len      <= WINDOW_LENGTH_RESET;
			model_periodic <= 1'b0;
			took           <= 1'b0;
		end else begin
			took <= start && !busy;
			if (start && !busy)
				coef_expected.push_back(hann_predict(sample_index, model_len, model_periodic));

			if (done) begin
				if (coef_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected result coef=%0d oor=%0b",
						coefficient, index_out_of_range));
				end else begin
					want = coef_expected.pop_front();
					if (coefficient !== want.coef)
						report_mismatch($sformatf("coefficient got %0d want %0d",
							coefficient, want.coef));
					if (index_out_of_range !== want.oor)
						report_mismatch($sformatf("index_out_of_range got %0b want %0b",
							index_out_of_range, want.oor));
				end
			end

			if (cfg_we) begin
				if (cfg_index == REG_WINDOW_LENGTH)
					model_len <= cfg_wdata;
				else
					model_periodic <= cfg_wdata[0];
			end

			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [LEN_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
	endtask

	task automatic set_window(input logic [LEN_W-1:0] len, input logic periodic);
		write_reg(REG_WINDOW_LENGTH, len);
		write_reg(REG_PERIODIC_MODE, {{(LEN_W-1){1'b0}}, periodic});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every request is taken and answered, then let the pipeline settle
	task automatic drain();
		do
			@(negedge clk);
		while (pending_index.size() != 0 || start || coef_expected.size() != 0);
		repeat (PIPE_DEPTH + 4) @(negedge clk);
	endtask

	// Mostly in-window indexes, some at the boundary, some anywhere in the field
	function automatic logic [INDEX_W-1:0] pick_index(input logic [LEN_W-1:0] len);
		int n_eff, r, v;
		n_eff = (len > MAX_LEN) ? MAX_LEN : int'(len);
		r = $urandom_range(99);
		if (n_eff > 0 && r < 80)
			v = $urandom_range(n_eff - 1, 0);
		else if (r < 90)
			v = n_eff - 1 + $urandom_range(2);
		else
			v = $urandom();
		if (v < 0)
			v = 0;
		return INDEX_W'(v);
	endfunction

	task automatic queue_indexes(input int unsigned idx[]);
		foreach (idx[i])
			pending_index.push_back(INDEX_W'(idx[i]));
	endtask

	initial begin
		logic [LEN_W-1:0] len;
		logic             periodic;

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset values first, then lengths one, zero, saturation, the maximum and two
		gap_pct = 22;
		queue_indexes('{0, 1, 255, 511, 512, 4095});
		drain();
		set_window(13'd1, 1'b0);
		queue_indexes('{0, 1});
		drain();
		set_window(13'd1, 1'b1);
		queue_indexes('{0, 4095});
		drain();
		set_window(13'd0, 1'b0);
		queue_indexes('{0, 4095});
		drain();
		set_window(13'd8191, 1'b0);
		queue_indexes('{4095, 4094, 0});
		drain();
		set_window(13'd4096, 1'b1);
		queue_indexes('{0, 2048, 4095});
		drain();
		set_window(13'd2, 1'b0);
		queue_indexes('{0, 1, 2});
		drain();

		// Random phases: sender idles rarely, then often, then never
		for (int p = 0; p < RAND_PHASES; p++) begin
			gap_pct = (p < 5) ? 22 : (p < 10) ? 81 : 0;
			periodic = (p < 4) ? p[0] : $urandom_range(1);
			case (p)
				0:       len = 13'd2;
				1:       len = 13'd4096;
				2:       len = LEN_W'($urandom_range(8191, 4097));
				3:       len = 13'd8191;
				5:       len = 13'd1;
				7:       len = 13'd0;
				8:       len = LEN_W'($urandom_range(16, 2));
				default: len = LEN_W'($urandom_range(4096, 2));
			endcase
			set_window(len, periodic);
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_index.push_back(pick_index(len));
			drain();
		end

		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ hann_window_coefficient.f @@
sv/hwc_pkg.sv
sv/hwc_div_stage.sv
sv/hwc_series_term.sv
sv/hann_window_coefficient.sv
bench/hann_window_coefficient_tb.sv
